// ----- sv/nbot_pkg.sv -----
// ----------------------------------------------------------------------------
// nbot_pkg: shared types and constants of the nearest blob object tracker
// Holds the controller state encoding, the command and status structs that
// join the controller to the datapath, and the register map.
// ----------------------------------------------------------------------------
package nbot_pkg;

    localparam int unsigned MaxObjectsDef = 16;
    localparam int unsigned MaxBlobsDef   = 16;
    localparam int unsigned CoordBitsDef  = 12;
    localparam int unsigned IdBitsDef     = 16;

    localparam int unsigned DimW   = 12;
    localparam int unsigned DistW  = 13;
    localparam int unsigned SpeedW = 13;
    localparam int unsigned OidW   = 16;
    localparam int unsigned AddrW  = 4;

    localparam logic [AddrW-1:0] RegMinWidth  = 4'h0;
    localparam logic [AddrW-1:0] RegMinHeight = 4'h4;
    localparam logic [AddrW-1:0] RegMatchDist = 4'h8;

    localparam logic [12:0] MatchDistReset = 13'd50;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_COMPACT,
        ST_CREATE,
        ST_EMIT
    } state_t;

    // Controller -> datapath commands.
    typedef struct packed {
        logic load;        // load one blob from the input
        logic obj_start;   // start the blob scan for the current object
        logic scan_step;   // evaluate one blob for the current object
        logic decide;      // commit the match of the current object
        logic compact;     // move one object down during compaction
        logic create;      // turn one blob into a new object
        logic emit_start;  // begin emitting results
        logic emit_next;   // advance to the next result
        logic frame_done;  // clear the blob store and the drop flag
    } cmd_t;

    // Datapath -> controller status.
    typedef struct packed {
        logic scan_last;   // the scan has reached the last stored blob
        logic obj_last;    // the current object index is the last one
        logic cmp_last;    // compaction has visited every object
        logic create_last; // creation has visited every blob
        logic emit_last;   // the result on the output is the final one
    } status_t;

endpackage

// ----- sv/nbot_datapath.sv -----
// ----------------------------------------------------------------------------
// nbot_datapath: object table, blob store and matching arithmetic
// Runs one blob comparison a cycle, compacts the table one entry a cycle and
// appends new objects one blob a cycle, under the controller's commands.
// ----------------------------------------------------------------------------
module nbot_datapath #(
    parameter int unsigned MAX_OBJECTS = nbot_pkg::MaxObjectsDef,
    parameter int unsigned MAX_BLOBS   = nbot_pkg::MaxBlobsDef,
    parameter int unsigned COORD_BITS  = nbot_pkg::CoordBitsDef,
    parameter int unsigned ID_BITS     = nbot_pkg::IdBitsDef
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  nbot_pkg::cmd_t          cmd,
    output nbot_pkg::status_t       status,
    input  logic [11:0]             min_width,
    input  logic [11:0]             min_height,
    input  logic [12:0]             match_distance,
    input  logic [11:0]             blob_x,
    input  logic [11:0]             blob_y,
    input  logic [11:0]             blob_width,
    input  logic [11:0]             blob_height,
    output logic [15:0]             object_id,
    output logic [11:0]             box_x,
    output logic [11:0]             box_y,
    output logic [11:0]             box_width,
    output logic [11:0]             box_height,
    output logic signed [12:0]      speed_x,
    output logic signed [12:0]      speed_y,
    output logic                    is_new,
    output logic                    present,
    output logic                    last,
    output logic                    dropped
);
    import nbot_pkg::*;

    localparam int unsigned OI = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int unsigned BI = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
    localparam int unsigned OC = $clog2(MAX_OBJECTS + 1);
    localparam int unsigned BC = $clog2(MAX_BLOBS + 1);
    localparam int unsigned CW = COORD_BITS;
    localparam int unsigned DW = CW + 1;
    localparam int unsigned SQ = 2 * DW + 1;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] w;
        logic [CW-1:0] h;
    } rect_t;

    // Object table (flip-flops, small).
    logic [MAX_OBJECTS-1:0]  obj_valid_reg;
    logic [MAX_OBJECTS-1:0]  obj_matched_reg;
    logic [MAX_OBJECTS-1:0]  obj_new_reg;
    logic [ID_BITS-1:0]      obj_ident_reg [MAX_OBJECTS];
    rect_t                   obj_rect_reg  [MAX_OBJECTS];
    logic signed [DW-1:0]    obj_sx_reg    [MAX_OBJECTS];
    logic signed [DW-1:0]    obj_sy_reg    [MAX_OBJECTS];

    // Blob store.
    rect_t                   blob_reg [MAX_BLOBS];
    logic [MAX_BLOBS-1:0]    blob_taken_reg;
    logic [BC-1:0]           blob_count_reg;
    logic [ID_BITS-1:0]      next_ident_reg;
    logic                    overflow_reg;

    // Scan and walk indexes.
    logic [OI-1:0]           oi_reg;
    logic [BI-1:0]           bj_reg;
    logic [OC-1:0]           src_reg;
    logic [OC-1:0]           n_reg;
    logic [SQ-1:0]           best_reg;
    logic [BI-1:0]           sel_reg;
    logic                    sel_ok_reg;
    logic [OC-1:0]           emit_reg;

    logic [CW-1:0]           in_x, in_y, in_w, in_h;
    logic                    qualifies;
    rect_t                   cur_blob;
    rect_t                   cur_obj;
    logic signed [DW-1:0]    dx, dy;
    logic [SQ-1:0]           dist_sq;
    logic [SQ-1:0]           thr_sq;
    logic                    closer;
    logic [OI-1:0]           src_idx;
    logic [OI-1:0]           n_idx;
    logic [OI-1:0]           emit_idx;
    logic [BI-1:0]           last_blob;

    assign in_x = CW'(blob_x);
    assign in_y = CW'(blob_y);
    assign in_w = CW'(blob_width);
    assign in_h = CW'(blob_height);
    assign qualifies = ({{(32-CW){1'b0}}, in_w} >= {20'd0, min_width}) &&
                       ({{(32-CW){1'b0}}, in_h} >= {20'd0, min_height});

    assign cur_blob = blob_reg[bj_reg];
    assign cur_obj  = obj_rect_reg[oi_reg];
    assign dx = $signed({1'b0, cur_blob.x}) - $signed({1'b0, cur_obj.x});
    assign dy = $signed({1'b0, cur_blob.y}) - $signed({1'b0, cur_obj.y});
    // Square at full width so large displacements do not wrap.
    assign dist_sq = $unsigned(SQ'(dx) * SQ'(dx)) + $unsigned(SQ'(dy) * SQ'(dy));
    assign thr_sq  = SQ'(match_distance) * SQ'(match_distance);
    assign closer  = !blob_taken_reg[bj_reg] && (dist_sq < best_reg);

    assign src_idx   = OI'(src_reg);
    assign n_idx     = OI'(n_reg);
    assign emit_idx  = OI'(emit_reg);
    assign last_blob = BI'(blob_count_reg - BC'(1));

    assign status.scan_last   = (blob_count_reg == '0) ||
                                (bj_reg == last_blob);
    assign status.obj_last    = (oi_reg == OI'(MAX_OBJECTS - 1));
    assign status.cmp_last    = (src_reg == OC'(MAX_OBJECTS - 1));
    assign status.create_last = (blob_count_reg == '0) ||
                                (bj_reg == last_blob);
    assign status.emit_last   = (n_reg == '0) || (emit_reg == n_reg - OC'(1));

    // Blob store, load and frame clear.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blob_count_reg <= '0;
            blob_taken_reg <= '0;
            overflow_reg   <= 1'b0;
        end else if (cmd.frame_done) begin
            blob_count_reg <= '0;
            blob_taken_reg <= '0;
            overflow_reg   <= 1'b0;
        end else begin
            if (cmd.load && qualifies) begin
                if (blob_count_reg >= BC'(MAX_BLOBS)) begin
                    overflow_reg <= 1'b1;
                end else begin
                    blob_reg[BI'(blob_count_reg)] <= '{in_x, in_y, in_w, in_h};
                    blob_count_reg <= blob_count_reg + BC'(1);
                end
            end
            if (cmd.decide && sel_ok_reg && obj_valid_reg[oi_reg]) begin
                blob_taken_reg[sel_reg] <= 1'b1;
            end
            if (cmd.create && (blob_count_reg != '0) && !blob_taken_reg[bj_reg] &&
                (n_reg >= OC'(MAX_OBJECTS))) begin
                overflow_reg <= 1'b1;
            end
        end
    end

    // Scan bookkeeping: best distance and winner for the current object.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oi_reg     <= '0;
            bj_reg     <= '0;
            sel_ok_reg <= 1'b0;
        end else begin
            if (cmd.obj_start) begin
                bj_reg     <= '0;
                best_reg   <= thr_sq;
                sel_ok_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                if (blob_count_reg != '0 && closer) begin
                    best_reg   <= dist_sq;
                    sel_reg    <= bj_reg;
                    sel_ok_reg <= 1'b1;
                end
                if (!status.scan_last) begin
                    bj_reg <= bj_reg + BI'(1);
                end
            end
            if (cmd.decide) begin
                oi_reg <= status.obj_last ? '0 : oi_reg + OI'(1);
            end
            if (cmd.compact) begin
                bj_reg <= '0;
            end
            if (cmd.create && !status.create_last) begin
                bj_reg <= bj_reg + BI'(1);
            end
        end
    end

    // Object table: match commit, compaction, creation.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obj_valid_reg   <= '0;
            obj_matched_reg <= '0;
            obj_new_reg     <= '0;
            next_ident_reg  <= '0;
            src_reg         <= '0;
            n_reg           <= '0;
        end else begin
            if (cmd.decide) begin
                obj_matched_reg[oi_reg] <= sel_ok_reg && obj_valid_reg[oi_reg];
                if (sel_ok_reg && obj_valid_reg[oi_reg]) begin
                    obj_sx_reg[oi_reg]   <= $signed({1'b0, blob_reg[sel_reg].x}) -
                                            $signed({1'b0, cur_obj.x});
                    obj_sy_reg[oi_reg]   <= $signed({1'b0, blob_reg[sel_reg].y}) -
                                            $signed({1'b0, cur_obj.y});
                    obj_rect_reg[oi_reg] <= blob_reg[sel_reg];
                end
                if (status.obj_last) begin
                    src_reg <= '0;
                    n_reg   <= '0;
                end
            end
            if (cmd.compact) begin
                obj_valid_reg[src_idx]   <= 1'b0;
                obj_matched_reg[src_idx] <= 1'b0;
                obj_new_reg[src_idx]     <= 1'b0;
                if (obj_valid_reg[src_idx] && obj_matched_reg[src_idx]) begin
                    obj_ident_reg[n_idx] <= obj_ident_reg[src_idx];
                    obj_rect_reg[n_idx]  <= obj_rect_reg[src_idx];
                    obj_sx_reg[n_idx]    <= obj_sx_reg[src_idx];
                    obj_sy_reg[n_idx]    <= obj_sy_reg[src_idx];
                    obj_valid_reg[n_idx] <= 1'b1;
                    n_reg <= n_reg + OC'(1);
                end
                src_reg <= src_reg + OC'(1);
            end
            if (cmd.create && (blob_count_reg != '0) && !blob_taken_reg[bj_reg] &&
                (n_reg < OC'(MAX_OBJECTS))) begin
                obj_valid_reg[n_idx] <= 1'b1;
                obj_new_reg[n_idx]   <= 1'b1;
                obj_ident_reg[n_idx] <= next_ident_reg;
                obj_rect_reg[n_idx]  <= cur_blob;
                obj_sx_reg[n_idx]    <= '0;
                obj_sy_reg[n_idx]    <= '0;
                next_ident_reg       <= next_ident_reg + ID_BITS'(1);
                n_reg                <= n_reg + OC'(1);
            end
        end
    end

    // Result walk.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_reg <= '0;
        end else if (cmd.emit_start) begin
            emit_reg <= '0;
        end else if (cmd.emit_next) begin
            emit_reg <= emit_reg + OC'(1);
        end
    end

    always_comb begin
        rect_t r;
        r = obj_rect_reg[emit_idx];
        present    = (n_reg != '0);
        last       = status.emit_last;
        dropped    = overflow_reg;
        object_id  = present ? 16'(obj_ident_reg[emit_idx]) : '0;
        box_x      = present ? 12'(r.x) : '0;
        box_y      = present ? 12'(r.y) : '0;
        box_width  = present ? 12'(r.w) : '0;
        box_height = present ? 12'(r.h) : '0;
        speed_x    = present ? 13'(obj_sx_reg[emit_idx]) : '0;
        speed_y    = present ? 13'(obj_sy_reg[emit_idx]) : '0;
        is_new     = present && obj_new_reg[emit_idx];
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        blob_count_reg <= BC'(MAX_BLOBS))
        else $error("blob count beyond store depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= OC'(MAX_OBJECTS))
        else $error("object count beyond table depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.frame_done |=> (blob_count_reg == '0) && !overflow_reg)
        else $error("blob store not cleared at end of frame");

endmodule

// ----- sv/nbot_ctrl.sv -----
// ----------------------------------------------------------------------------
// nbot_ctrl: sequencer of the tracker
// Steps through scan, compaction, creation and result output for each frame.
// ----------------------------------------------------------------------------
module nbot_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    output logic                m_valid,
    input  logic                m_ready,
    input  nbot_pkg::status_t   status,
    output nbot_pkg::cmd_t      cmd
);
    import nbot_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_valid && s_action) state_next = ST_SCAN;
            ST_SCAN:    if (status.scan_last) state_next = ST_DECIDE;
            ST_DECIDE:  if (status.obj_last) state_next = ST_COMPACT;
                        else state_next = ST_SCAN;
            ST_COMPACT: if (status.cmp_last) state_next = ST_CREATE;
            ST_CREATE:  if (status.create_last) state_next = ST_EMIT;
            ST_EMIT:    if (m_ready && status.emit_last) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load      = s_valid && !s_action;
                cmd.obj_start = s_valid && s_action;
            end
            ST_SCAN:    cmd.scan_step = 1'b1;
            ST_DECIDE: begin
                cmd.decide    = 1'b1;
                cmd.obj_start = 1'b1;
            end
            ST_COMPACT: cmd.compact = 1'b1;
            ST_CREATE: begin
                cmd.create     = 1'b1;
                cmd.emit_start = status.create_last;
            end
            ST_EMIT: begin
                m_valid        = 1'b1;
                cmd.emit_next  = m_ready;
                cmd.frame_done = m_ready && status.emit_last;
            end
            default: ;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while results pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE && status.obj_last) |=> state_reg == ST_COMPACT)
        else $error("scan did not hand over to compaction");
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.scan_step, cmd.compact, cmd.create, cmd.emit_next}))
        else $error("conflicting datapath commands");

endmodule

// ----- sv/nearest_blob_object_tracker.sv -----
// ----------------------------------------------------------------------------
// nearest_blob_object_tracker: greedy nearest-neighbor blob tracker
// Loads one frame's blobs, matches tracked objects to the nearest blob at
// end of frame, evicts the unmatched, adds new objects, and emits the table.
// ----------------------------------------------------------------------------
//  channel   ports                    direction  carries
//  s_        s_valid/s_ready + blob   in         load request or end of frame
//  m_        m_valid/m_ready + object out        one tracked object per request
//  apb       psel/penable/pwrite/...  in         min_width, min_height, match_dist
//
//  Blob loads may arrive back to back.
//  End of frame scans every object over the stored blobs on the single
//  shared comparator, then compacts the table and creates new objects.
//  Results then follow one per cycle while m_ready is high; input holds off
//  until the last result is taken.
//  Reset (aresetn low at a clock edge) empties the object table and the store.
module nearest_blob_object_tracker #(
    parameter int unsigned MAX_OBJECTS = nbot_pkg::MaxObjectsDef,
    parameter int unsigned MAX_BLOBS   = nbot_pkg::MaxBlobsDef,
    parameter int unsigned COORD_BITS  = nbot_pkg::CoordBitsDef,
    parameter int unsigned ID_BITS     = nbot_pkg::IdBitsDef
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nbot_pkg::AddrW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_action,
    input  logic [11:0]                 s_blob_x,
    input  logic [11:0]                 s_blob_y,
    input  logic [11:0]                 s_blob_width,
    input  logic [11:0]                 s_blob_height,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [15:0]                 m_object_id,
    output logic [11:0]                 m_box_x,
    output logic [11:0]                 m_box_y,
    output logic [11:0]                 m_box_width,
    output logic [11:0]                 m_box_height,
    output logic signed [12:0]          m_speed_x,
    output logic signed [12:0]          m_speed_y,
    output logic                        m_is_new,
    output logic                        m_present,
    output logic                        m_last,
    output logic                        m_dropped
);
    import nbot_pkg::*;

    logic [11:0] min_width_reg;
    logic [11:0] min_height_reg;
    logic [12:0] match_dist_reg;
    cmd_t        cmd;
    status_t     status;

    assign pready = 1'b1;

    // Register writes complete in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_width_reg  <= '0;
            min_height_reg <= '0;
            match_dist_reg <= MatchDistReset;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                RegMinWidth:  min_width_reg  <= pwdata[11:0];
                RegMinHeight: min_height_reg <= pwdata[11:0];
                RegMatchDist: match_dist_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            RegMinWidth:  prdata = {20'd0, min_width_reg};
            RegMinHeight: prdata = {20'd0, min_height_reg};
            RegMatchDist: prdata = {19'd0, match_dist_reg};
            default:      prdata = '0;
        endcase
    end

    nbot_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    nbot_datapath #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .MAX_BLOBS   (MAX_BLOBS),
        .COORD_BITS  (COORD_BITS),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .min_width      (min_width_reg),
        .min_height     (min_height_reg),
        .match_distance (match_dist_reg),
        .blob_x         (s_blob_x),
        .blob_y         (s_blob_y),
        .blob_width     (s_blob_width),
        .blob_height    (s_blob_height),
        .object_id      (m_object_id),
        .box_x          (m_box_x),
        .box_y          (m_box_y),
        .box_width      (m_box_width),
        .box_height     (m_box_height),
        .speed_x        (m_speed_x),
        .speed_y        (m_speed_y),
        .is_new         (m_is_new),
        .present        (m_present),
        .last           (m_last),
        .dropped        (m_dropped)
    );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the nearest blob object tracker
// Drives frames of blob loads and end-of-frame requests over the input channel,
// predicts the emitted object table in a local model of the tracker, and checks
// every result field by field. Registers are set over APB between frames.
// ----------------------------------------------------------------------------
module testbench;
    import nbot_pkg::*;

    localparam int unsigned NumObj   = 16;
    localparam int unsigned NumBlob  = 16;
    localparam int unsigned LimitCyc = 1000000;
    localparam int unsigned StallCyc = 600;

    localparam bit ActLoad = 1'b0;
    localparam bit ActEnd  = 1'b1;

    typedef struct packed {
        logic [15:0] oid;
        logic [11:0] bx;
        logic [11:0] by;
        logic [11:0] bw;
        logic [11:0] bh;
        logic [12:0] sx;
        logic [12:0] sy;
        logic        is_new;
        logic        present;
        logic        last;
        logic        dropped;
    } track_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0, s_ready, s_action = 1'b0;
    logic [11:0] s_blob_x = '0, s_blob_y = '0, s_blob_width = '0, s_blob_height = '0;
    logic m_valid, m_ready = 1'b0;
    logic [15:0] m_object_id;
    logic [11:0] m_box_x, m_box_y, m_box_width, m_box_height;
    logic signed [12:0] m_speed_x, m_speed_y;
    logic m_is_new, m_present, m_last, m_dropped;

    nearest_blob_object_tracker uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state: configuration, object table and this frame's blobs.
    logic [11:0] cfg_min_w, cfg_min_h;
    logic [12:0] cfg_match;
    bit          trk_valid [NumObj];
    logic [15:0] trk_id    [NumObj];
    logic [11:0] trk_rect  [NumObj][4];
    logic [12:0] trk_speed [NumObj][2];
    logic [11:0] blob_rect [NumBlob][4];
    int unsigned blob_cnt;
    logic [15:0] id_next;
    bit          lost_flag;

    track_t expected_tracks[$];
    int unsigned mismatches = 0;
    longint unsigned cycles = 0;
    bit hold_off = 1'b0;

    // Predict one request; queue any results it causes.
    task automatic predict_request(input bit act, input logic [11:0] x, y, w, h);
        bit          hit [NumObj];
        bit          taken [NumBlob];
        longint      best, d, dx, dy;
        int          sel, n, old_n;
        track_t      r;
        if (act == ActLoad) begin
            if (w < cfg_min_w || h < cfg_min_h) return;
            if (blob_cnt >= NumBlob) begin
                lost_flag = 1'b1;
                return;
            end
            blob_rect[blob_cnt] = '{x, y, w, h};
            blob_cnt++;
            return;
        end
        foreach (taken[j]) taken[j] = 1'b0;
        // Greedy match, table order, first minimum wins.
        for (int i = 0; i < NumObj; i++) begin
            hit[i] = 1'b0;
            if (!trk_valid[i]) continue;
            best = longint'(cfg_match) * longint'(cfg_match);
            sel = -1;
            for (int j = 0; j < blob_cnt; j++) begin
                if (taken[j]) continue;
                dx = longint'(blob_rect[j][0]) - longint'(trk_rect[i][0]);
                dy = longint'(blob_rect[j][1]) - longint'(trk_rect[i][1]);
                d = dx * dx + dy * dy;
                if (d < best) begin
                    best = d;
                    sel = j;
                end
            end
            if (sel >= 0) begin
                trk_speed[i][0] = 13'(longint'(blob_rect[sel][0]) - longint'(trk_rect[i][0]));
                trk_speed[i][1] = 13'(longint'(blob_rect[sel][1]) - longint'(trk_rect[i][1]));
                trk_rect[i] = blob_rect[sel];
                hit[i] = 1'b1;
                taken[sel] = 1'b1;
            end
        end
        // Evict unmatched, compact in order.
        n = 0;
        for (int i = 0; i < NumObj; i++) begin
            if (trk_valid[i] && hit[i]) begin
                trk_id[n] = trk_id[i];
                trk_rect[n] = trk_rect[i];
                trk_speed[n] = trk_speed[i];
                n++;
            end
        end
        for (int i = 0; i < NumObj; i++) trk_valid[i] = (i < n);
        old_n = n;
        // Spawn new objects from untaken blobs.
        for (int j = 0; j < blob_cnt; j++) begin
            if (taken[j]) continue;
            if (n >= NumObj) begin
                lost_flag = 1'b1;
                continue;
            end
            trk_valid[n] = 1'b1;
            trk_id[n] = id_next;
            trk_rect[n] = blob_rect[j];
            trk_speed[n] = '{13'd0, 13'd0};
            id_next++;
            n++;
        end
        if (n == 0) begin
            r = '0;
            r.last = 1'b1;
            r.dropped = lost_flag;
            expected_tracks.insert(expected_tracks.size(), r);
        end else begin
            for (int i = 0; i < n; i++) begin
                r.oid = trk_id[i];
                r.bx = trk_rect[i][0];
                r.by = trk_rect[i][1];
                r.bw = trk_rect[i][2];
                r.bh = trk_rect[i][3];
                r.sx = trk_speed[i][0];
                r.sy = trk_speed[i][1];
                r.is_new = (i >= old_n);
                r.present = 1'b1;
                r.last = (i + 1 == n);
                r.dropped = lost_flag;
                expected_tracks.insert(expected_tracks.size(), r);
            end
        end
        blob_cnt = 0;
        lost_flag = 1'b0;
    endtask

    // Send one request after a random gap; hold it until accepted.
    // Valid stays high after acceptance so a zero gap gives back-to-back requests.
    task automatic send_request(input bit act, input logic [11:0] x, y, w, h);
        int unsigned gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_blob_x <= x;
        s_blob_y <= y;
        s_blob_width <= w;
        s_blob_height <= h;
        predict_request(act, x, y, w, h);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_blob(input logic [11:0] x, y, w, h);
        send_request(ActLoad, x, y, w, h);
    endtask

    task automatic end_frame();
        send_request(ActEnd, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
    endtask

    // Drop the input, wait for the block to drain, then write one register.
    task automatic write_reg(input logic [AddrW-1:0] addr, input logic [31:0] val);
        s_valid <= 1'b0;
        while (expected_tracks.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            RegMinWidth:  cfg_min_w = val[11:0];
            RegMinHeight: cfg_min_h = val[11:0];
            RegMatchDist: cfg_match = val[12:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [11:0] mw, mh, input logic [12:0] md);
        write_reg(RegMinWidth, 32'(mw));
        write_reg(RegMinHeight, 32'(mh));
        write_reg(RegMatchDist, 32'(md));
    endtask

    // Directed: empty frame, field extremes, exact-threshold, tie, size filter.
    task automatic test_directed();
        end_frame();
        send_blob(12'd0, 12'd0, 12'd0, 12'd0);
        send_blob(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        end_frame();
        // Same corners move: speed positive and negative extremes.
        send_blob(12'd30, 12'd0, 12'd1, 12'd1);
        send_blob(12'hFFF, 12'hFD0, 12'd2, 12'd2);
        end_frame();
        // Distance exactly at the threshold does not match; just below does.
        send_blob(12'd80, 12'd0, 12'd5, 12'd5);
        send_blob(12'hFFF, 12'hFA1, 12'd5, 12'd5);
        end_frame();
        // Tie: two blobs equidistant, earliest wins.
        send_blob(12'd70, 12'd10, 12'd3, 12'd3);
        send_blob(12'd90, 12'd10, 12'd4, 12'd4);
        end_frame();
        // Everything evicted.
        end_frame();
        set_config(12'd10, 12'd10, 13'h1FFF);
        send_blob(12'd5, 12'd5, 12'd9, 12'd20);
        send_blob(12'd5, 12'd5, 12'd20, 12'd9);
        send_blob(12'd5, 12'd5, 12'd10, 12'd10);
        end_frame();
        set_config(12'd0, 12'd0, 13'd0);
        end_frame();
    endtask

    // Overfill the blob store and the object table so drops are flagged.
    task automatic test_overflow();
        set_config(12'd0, 12'd0, 13'd0);
        repeat (2) begin
            repeat (20) send_blob(12'($urandom), 12'($urandom), 12'($urandom),
                                  12'($urandom));
            end_frame();
        end
        set_config(12'd0, 12'd0, 13'd1);
        repeat (10) send_blob(12'($urandom), 12'($urandom), 12'($urandom),
                              12'($urandom));
        end_frame();
        set_config(12'hFFF, 12'hFFF, 13'd50);
        repeat (3) send_blob(12'($urandom), 12'($urandom), 12'($urandom), 12'hFFE);
        send_blob(12'd1, 12'd2, 12'hFFF, 12'hFFF);
        end_frame();
    endtask

    // Random frames: blobs jittered around current tracks plus fresh ones.
    task automatic test_random_frames(input int unsigned budget);
        int unsigned sent = 0;
        int nb;
        logic [11:0] x, y;
        while (sent < budget) begin
            if ($urandom_range(0, 5) == 0)
                set_config($urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 8)),
                           $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 8)),
                           $urandom_range(0, 5) == 0 ? 13'($urandom) : 13'($urandom_range(0, 120)));
            nb = $urandom_range(0, 18);
            for (int k = 0; k < nb; k++) begin
                if (trk_valid[k % NumObj] && $urandom_range(0, 3) != 0) begin
                    x = trk_rect[k % NumObj][0] + 12'($urandom_range(0, 80)) - 12'd40;
                    y = trk_rect[k % NumObj][1] + 12'($urandom_range(0, 80)) - 12'd40;
                end else begin
                    x = 12'($urandom);
                    y = 12'($urandom);
                end
                send_blob(x, y, $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 20)),
                          $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 20)));
                sent++;
            end
            end_frame();
            sent++;
        end
    endtask

    // Stall the result side for a long stretch while further frames wait to be sent.
    task automatic test_backpressure();
        set_config(12'd0, 12'd0, 13'd60);
        hold_off = 1'b1;
        repeat (3) begin
            repeat (12) send_blob(12'($urandom_range(0, 200)), 12'($urandom_range(0, 200)),
                                  12'd4, 12'd4);
            end_frame();
        end
    endtask

    // Receiver: insert a random pause before each result; take none during a hold-off.
    int unsigned rx_wait = 0;
    always @(posedge aclk) begin
        int unsigned pause;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (hold_off) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            pause = $urandom_range(0, 3);
            rx_wait <= pause;
            m_ready <= (pause == 0);
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= (rx_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Long-stall counter: release hold_off once stall_cnt reaches StallCyc.
    int unsigned stall_cnt = 0;
    always @(posedge aclk) begin
        if (hold_off) begin
            if (stall_cnt >= StallCyc) begin
                hold_off  <= 1'b0;
                stall_cnt <= 0;
            end else begin
                stall_cnt <= stall_cnt + 1;
            end
        end
    end

    // Check each result against the oldest prediction.
    always @(posedge aclk) begin
        track_t want, got;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_object_id, m_box_x, m_box_y, m_box_width, m_box_height,
                    m_speed_x, m_speed_y, m_is_new, m_present, m_last, m_dropped};
            if (expected_tracks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_tracks.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
        if (cycles >= LimitCyc) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        cfg_min_w = '0;
        cfg_min_h = '0;
        cfg_match = MatchDistReset;
        foreach (trk_valid[i]) trk_valid[i] = 1'b0;
        blob_cnt = 0;
        id_next = '0;
        lost_flag = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_overflow();
        test_backpressure();
        test_random_frames(250);
        set_config(12'd0, 12'd0, 13'd50);
        // Walk ids forward so the counter wraps is not needed; keep run short.
        while (expected_tracks.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && expected_tracks.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
sv/nbot_pkg.sv
sv/nbot_datapath.sv
sv/nbot_ctrl.sv
sv/nearest_blob_object_tracker.sv
test/testbench.sv
